### rtl/pll_pkg.sv
// ----------------------------------------------------------------------------
// pll_pkg: shared types and codes for the positional linked list
// Field types, command, place and status codes, and the cell select code.
// ----------------------------------------------------------------------------
package pll_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int PLACE_W = 2;
   localparam int POS_W   = 7;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 3;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic [PLACE_W-1:0]        place_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic signed [VAL_W-1:0]   value_type;
   typedef logic [STAT_W-1:0]         status_type;

   // command codes
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_LIST   = 2'd2;

   // place codes
   localparam place_type PLACE_FRONT = 2'd0;
   localparam place_type PLACE_AT    = 2'd1;
   localparam place_type PLACE_END   = 2'd2;
   localparam place_type PLACE_BAD   = 2'd3;

   // result status codes
   localparam status_type ST_DONE  = 3'd0;
   localparam status_type ST_ELEM  = 3'd1;
   localparam status_type ST_FULL  = 3'd2;
   localparam status_type ST_NONE  = 3'd3;
   localparam status_type ST_EMPTY = 3'd4;

   // what a cell loads on the next edge
   typedef enum logic [2:0] {
      SEL_HOLD  = 3'd0,
      SEL_LEFT  = 3'd1,
      SEL_RIGHT = 3'd2,
      SEL_NEW   = 3'd3,
      SEL_HEAD  = 3'd4
   } sel_type;

endpackage

### rtl/pll_cell.sv
// ----------------------------------------------------------------------------
// pll_cell: one element slot of the list chain
// Holds one value and loads it from a neighbor, the head or a new value.
// ----------------------------------------------------------------------------
module pll_cell (
   input  logic                clock,
   input  pll_pkg::sel_type    sel,
   input  pll_pkg::value_type  left_data,
   input  pll_pkg::value_type  right_data,
   input  pll_pkg::value_type  head_data,
   input  pll_pkg::value_type  new_data,
   output pll_pkg::value_type  data
);
   import pll_pkg::*;

   value_type data_ff;
   value_type data_in;

   // source select
   always_comb begin
      case (sel)
         SEL_LEFT:  data_in = left_data;
         SEL_RIGHT: data_in = right_data;
         SEL_HEAD:  data_in = head_data;
         SEL_NEW:   data_in = new_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### rtl/positional_linked_list.sv
// ----------------------------------------------------------------------------
// positional_linked_list: bounded ordered list with positional insert/delete
// Values are kept in list order in a chain of cells; inserts and deletes
// shift part of the chain, listing rotates it past cell zero.
// ----------------------------------------------------------------------------
// Usage: an insert or delete beat gives a single result, registered in the
// cycle after the beat is taken. A list beat of n elements (n up to CAPACITY)
// gives n result beats, one per cycle while results are not stalled, taken
// from cell zero while the first n cells rotate by one place per result; the
// input is stalled while the listing runs, and the chain returns to list order
// when the last element goes out. An empty listing gives one result. A new
// beat is taken only while no listing runs and the result register is free or
// drained in that cycle.
module positional_linked_list #(
   parameter int CAPACITY = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pll_pkg::cmd_type      req_cmd,
   input  pll_pkg::place_type    req_place,
   input  pll_pkg::pos_type      req_position,
   input  pll_pkg::value_type    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pll_pkg::value_type    rsp_item,
   output pll_pkg::status_type   rsp_status,
   output logic                  rsp_last
);
   import pll_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  remain_ff, remain_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_item_ff, rsp_item_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic           rsp_last_ff, rsp_last_in;

   value_type      cell_data [CAPACITY];
   sel_type        cell_sel  [CAPACITY];

   logic           slot_free;
   logic           accept;
   logic           ins_en, del_en, rot_en;
   logic [CW-1:0]  tgt;
   logic [CW-1:0]  last_idx;
   pos_type        k_raw;
   logic [CW-1:0]  anchor;

   // result register free this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   // anchor position max(position-1,1) clamped to the tail
   assign k_raw    = (req_position > POS_W'(2)) ? req_position - POS_W'(1) : POS_W'(1);
   assign anchor   = (k_raw > POS_W'(count_ff)) ? count_ff : CW'(k_raw);
   assign last_idx = count_ff - CW'(1);

   // command decode and control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ins_en        = 1'b0;
      del_en        = 1'b0;
      rot_en        = 1'b0;
      tgt           = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_status_in = ST_DONE;
               rsp_last_in   = 1'b1;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (req_place == PLACE_BAD) begin
                        rsp_status_in = ST_DONE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ins_en   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (count_ff == '0 || req_place == PLACE_FRONT) begin
                           tgt = '0;
                        end else if (req_place == PLACE_AT) begin
                           tgt = anchor;
                        end else begin
                           tgt = count_ff;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (req_place == PLACE_BAD) begin
                        rsp_status_in = ST_DONE;
                     end else if (count_ff == '0) begin
                        rsp_status_in = ST_NONE;
                     end else if (req_place == PLACE_AT && anchor >= count_ff) begin
                        rsp_status_in = ST_NONE;
                     end else begin
                        del_en   = 1'b1;
                        count_in = count_ff - CW'(1);
                        if (req_place == PLACE_FRONT) begin
                           tgt = '0;
                        end else if (req_place == PLACE_AT) begin
                           tgt = anchor;
                        end else begin
                           tgt = last_idx;
                        end
                     end
                  end
                  CMD_LIST: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        remain_in    = count_ff;
                        state_in     = S_LIST;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_LIST: begin
            // one element a cycle out of cell zero while the result register is free
            if (slot_free) begin
               rot_en        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_item_in   = cell_data[0];
               rsp_status_in = ST_ELEM;
               rsp_last_in   = (remain_ff == CW'(1));
               remain_in     = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_d;
      value_type right_d;

      if (i == 0) begin : g_first
         assign left_d = cell_data[i];
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end

      // per-cell move decision
      always_comb begin
         cell_sel[i] = SEL_HOLD;
         if (ins_en) begin
            if (CW'(i) > tgt) begin
               cell_sel[i] = SEL_LEFT;
            end else if (CW'(i) == tgt) begin
               cell_sel[i] = SEL_NEW;
            end
         end else if (del_en) begin
            if (CW'(i) >= tgt) begin
               cell_sel[i] = SEL_RIGHT;
            end
         end else if (rot_en) begin
            if (CW'(i) < last_idx) begin
               cell_sel[i] = SEL_RIGHT;
            end else if (CW'(i) == last_idx) begin
               cell_sel[i] = SEL_HEAD;
            end
         end
      end

      pll_cell u_cell (
         .clock      (clock),
         .sel        (cell_sel[i]),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .new_data   (req_value),
         .data       (cell_data[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### rtl/pll_checker.sv
// ----------------------------------------------------------------------------
// pll_checker: port-level checks for the positional linked list
// Watches the request and result beats of the top level over time.
// ----------------------------------------------------------------------------
module pll_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pll_pkg::value_type   rsp_item,
   input  pll_pkg::status_type  rsp_status,
   input  logic                 rsp_last
);
   import pll_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_item) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // only list elements may be followed by more beats of the same command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ELEM |-> rsp_last)
      else $error("non-element result without last");

   // non-element results carry a zero item
   a_zero_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ELEM |-> rsp_item == '0)
      else $error("non-element result with nonzero item");

   // no request beat taken while a result beat sits stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("request beat taken over a stalled result");

endmodule

bind positional_linked_list pll_checker u_pll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_item   (rsp_item),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);
